>>> rtl/afs_pkg.sv
// Shared types, widths, mode codes and the per-mode operation program of the face flux solver.
package afs_pkg;

    // Field and internal widths
    localparam int DW      = 32;          // signed Q16.16 data
    localparam int FB      = 16;          // fraction bits
    localparam int TW      = 31;          // tau and sound speed width
    localparam int ZW      = 47;          // impedance width
    localparam int SW      = 50;          // width of the final signed sums
    localparam int NUM_W   = 94;          // divider numerator / quotient width
    localparam int DEN_W   = 48;          // divider denominator width
    localparam int MW      = 48;          // multiplier operand width
    localparam int MCH     = 16;          // multiplier chunk per cycle
    localparam int MUL_STEPS = MW / MCH;
    localparam int PW      = 2 * MW;      // product width
    localparam int RW      = 62;          // c^2 / tau width
    localparam int MAG_W   = 32;          // |du|, |dp| width
    localparam int TP_W    = 41;          // capped product term width
    localparam int SQ_W    = NUM_W / 2;   // square root result width
    localparam int PC_W    = 4;

    localparam logic [TP_W-1:0] TERM_CAP = TP_W'(1) << 40;

    // Scheme mode codes
    localparam logic [1:0] MODE_MEAN     = 2'd0;
    localparam logic [1:0] MODE_MAX      = 2'd1;
    localparam logic [1:0] MODE_WEIGHTED = 2'd2;

    typedef enum logic [1:0] {OP_DIV, OP_MUL, OP_SQRT} op_t;
    typedef enum logic [2:0] {NUM_C0, NUM_C1, NUM_ADP, NUM_PROD, NUM_R} num_sel_t;
    typedef enum logic [2:0] {DEN_T0, DEN_T1, DEN_2Z, DEN_S, DEN_MI} den_sel_t;
    typedef enum logic [2:0] {MA_C0, MA_C1, MA_Z, MA_Z0, MA_Z1, MA_H} ma_sel_t;
    typedef enum logic [2:0] {MB_C0, MB_C1, MB_ADU, MB_ADP, MB_Z1} mb_sel_t;
    typedef enum logic [3:0] {
        DST_Z0, DST_Z1, DST_R0, DST_R1, DST_Q, DST_ZS, DST_TU, DST_H, DST_A1, DST_B1
    } dst_t;

    typedef struct packed {
        op_t      op;
        num_sel_t num;
        den_sel_t den;
        ma_sel_t  ma;
        mb_sel_t  mb;
        dst_t     dst;
        logic     last;
    } uop_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic load_out;
        uop_t uop;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       had;
        logic       done;
        logic       out_free;
        logic [1:0] mode;
    } dp_stat_t;

    function automatic uop_t mk(op_t op, num_sel_t num, den_sel_t den, ma_sel_t ma,
                                mb_sel_t mb, dst_t dst, logic last);
        uop_t u;
        u.op   = op;
        u.num  = num;
        u.den  = den;
        u.ma   = ma;
        u.mb   = mb;
        u.dst  = dst;
        u.last = last;
        return u;
    endfunction

    // Operation sequence for one face, per mode
    function automatic uop_t prog_step(logic [1:0] mode, logic [PC_W-1:0] pc);
        uop_t u;
        u = mk(OP_MUL, NUM_C0, DEN_T0, MA_Z, MB_ADU, DST_TU, 1'b1);
        if (mode == MODE_MEAN) begin
            unique case (pc)
                4'd0:    u = mk(OP_DIV, NUM_C0, DEN_T0, MA_C0, MB_C0, DST_Z0, 1'b0);
                4'd1:    u = mk(OP_DIV, NUM_C1, DEN_T1, MA_C0, MB_C0, DST_Z1, 1'b0);
                4'd2:    u = mk(OP_DIV, NUM_ADP, DEN_2Z, MA_C0, MB_C0, DST_TU, 1'b0);
                default: u = mk(OP_MUL, NUM_C0, DEN_T0, MA_Z, MB_ADU, DST_TU, 1'b1);
            endcase
        end else if (mode == MODE_MAX) begin
            unique case (pc)
                4'd0:    u = mk(OP_MUL, NUM_C0, DEN_T0, MA_C0, MB_C0, DST_Z0, 1'b0);
                4'd1:    u = mk(OP_DIV, NUM_PROD, DEN_T0, MA_C0, MB_C0, DST_R0, 1'b0);
                4'd2:    u = mk(OP_MUL, NUM_C0, DEN_T0, MA_C1, MB_C1, DST_Z0, 1'b0);
                4'd3:    u = mk(OP_DIV, NUM_PROD, DEN_T1, MA_C0, MB_C0, DST_R1, 1'b0);
                4'd4:    u = mk(OP_DIV, NUM_R, DEN_MI, MA_C0, MB_C0, DST_Q, 1'b0);
                4'd5:    u = mk(OP_SQRT, NUM_R, DEN_MI, MA_C0, MB_C0, DST_ZS, 1'b0);
                4'd6:    u = mk(OP_DIV, NUM_ADP, DEN_2Z, MA_C0, MB_C0, DST_TU, 1'b0);
                default: u = mk(OP_MUL, NUM_C0, DEN_T0, MA_Z, MB_ADU, DST_TU, 1'b1);
            endcase
        end else begin
            unique case (pc)
                4'd0:    u = mk(OP_DIV, NUM_C0, DEN_T0, MA_C0, MB_C0, DST_Z0, 1'b0);
                4'd1:    u = mk(OP_DIV, NUM_C1, DEN_T1, MA_C0, MB_C0, DST_Z1, 1'b0);
                4'd2:    u = mk(OP_MUL, NUM_C0, DEN_T0, MA_Z0, MB_Z1, DST_Z0, 1'b0);
                4'd3:    u = mk(OP_DIV, NUM_PROD, DEN_S, MA_C0, MB_C0, DST_H, 1'b0);
                4'd4:    u = mk(OP_MUL, NUM_C0, DEN_T0, MA_Z0, MB_ADU, DST_Z0, 1'b0);
                4'd5:    u = mk(OP_DIV, NUM_PROD, DEN_S, MA_C0, MB_C0, DST_A1, 1'b0);
                4'd6:    u = mk(OP_DIV, NUM_ADP, DEN_S, MA_C0, MB_C0, DST_TU, 1'b0);
                4'd7:    u = mk(OP_MUL, NUM_C0, DEN_T0, MA_Z1, MB_ADP, DST_Z0, 1'b0);
                4'd8:    u = mk(OP_DIV, NUM_PROD, DEN_S, MA_C0, MB_C0, DST_B1, 1'b0);
                default: u = mk(OP_MUL, NUM_C0, DEN_T0, MA_H, MB_ADU, DST_TU, 1'b1);
            endcase
        end
        return u;
    endfunction

endpackage

>>> rtl/afs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module afs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [afs_pkg::NUM_W-1:0]     num,
    input  logic [afs_pkg::DEN_W-1:0]     den,
    output logic [afs_pkg::NUM_W-1:0]     quo,
    output logic                          done
);
    localparam int CNT_W = $clog2(afs_pkg::NUM_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [afs_pkg::DEN_W-1:0]   den_reg;
    logic [afs_pkg::DEN_W-1:0]   rem_reg;
    logic [afs_pkg::DEN_W-1:0]   rem_next;
    logic [afs_pkg::NUM_W-1:0]   quo_reg;
    logic [afs_pkg::DEN_W:0]     trial;
    logic [afs_pkg::DEN_W:0]     diff;
    logic                        ge;
    logic                        last;

    // One restoring step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[afs_pkg::NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[afs_pkg::DEN_W-1:0] : trial[afs_pkg::DEN_W-1:0];
        last     = (cnt_reg == CNT_W'(afs_pkg::NUM_W - 1));
    end

    // Control: count the steps, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: shift the numerator through, build the quotient in place
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[afs_pkg::NUM_W-2:0], ge};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

>>> rtl/afs_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module afs_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [afs_pkg::NUM_W-1:0]   rad,
    output logic [afs_pkg::SQ_W-1:0]    root,
    output logic                        done
);
    localparam int CNT_W = $clog2(afs_pkg::SQ_W);
    localparam int RM_W  = afs_pkg::SQ_W + 2;

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [afs_pkg::NUM_W-1:0]   rad_reg;
    logic [RM_W-1:0]             rem_reg;
    logic [afs_pkg::SQ_W-1:0]    root_reg;
    logic [RM_W+1:0]             trial;
    logic [RM_W+1:0]             cmp;
    logic [RM_W+1:0]             diff;
    logic                        ge;
    logic                        last;

    // One root digit
    always_comb
    begin
        trial = {rem_reg, rad_reg[afs_pkg::NUM_W-1 -: 2]};
        cmp   = {2'b00, root_reg, 2'b01};
        diff  = trial - cmp;
        ge    = (trial >= cmp);
        last  = (cnt_reg == CNT_W'(afs_pkg::SQ_W - 1));
    end

    // Control: count the digits, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: consume two radicand bits per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[afs_pkg::NUM_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[RM_W-1:0] : trial[RM_W-1:0];
            root_reg <= {root_reg[afs_pkg::SQ_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

>>> rtl/afs_dp.sv
// Datapath: cell registers, shared multiplier, divider and root units, result sums and output register.
module afs_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [1:0]                         scheme_mode,
    input  logic [afs_pkg::TW-1:0]             cell_volume,
    input  logic signed [afs_pkg::DW-1:0]      cell_velocity,
    input  logic signed [afs_pkg::DW-1:0]      cell_pressure,
    input  logic [afs_pkg::TW-1:0]             cell_sound_speed,
    input  logic                               first_cell,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic signed [afs_pkg::DW-1:0]      face_velocity,
    output logic signed [afs_pkg::DW-1:0]      face_pressure,
    output logic                               saturated,
    input  afs_pkg::ctrl_cmd_t                 cmd,
    output afs_pkg::dp_stat_t                  stat
);
    localparam int SW  = afs_pkg::SW;
    localparam int ZW  = afs_pkg::ZW;
    localparam int MW  = afs_pkg::MW;
    localparam int TW  = afs_pkg::TW;
    localparam int MCW = $clog2(afs_pkg::MUL_STEPS);

    function automatic logic signed [SW-1:0] apply_sign(logic neg, logic [SW-1:0] mag);
        logic signed [SW-1:0] m;
        m = $signed(mag);
        return neg ? -m : m;
    endfunction

    function automatic logic signed [SW-1:0] ext32(logic [afs_pkg::DW-1:0] v);
        return $signed({{(SW-afs_pkg::DW){v[afs_pkg::DW-1]}}, v});
    endfunction

    // Configuration and cell state
    logic [1:0]                    mode_reg;
    logic                          prev_valid_reg;
    logic [TW-1:0]                 a_tau_reg, b_tau_reg, a_snd_reg, b_snd_reg;
    logic [afs_pkg::DW-1:0]        a_vel_reg, b_vel_reg, a_prs_reg, b_prs_reg;
    logic [TW-1:0]                 tau_in;

    // Intermediate results
    logic [ZW-1:0]                 z0_reg, z1_reg, zs_reg, tu_reg, h_reg;
    logic [afs_pkg::RW-1:0]        r0_reg, r1_reg;
    logic [afs_pkg::NUM_W-1:0]     q_reg;
    logic [afs_pkg::MAG_W-1:0]     a1_reg, b1_reg;

    // Multiplier
    logic                          mbusy_reg;
    logic [MCW-1:0]                mcnt_reg;
    logic [MW-1:0]                 ma_reg, mb_reg;
    logic [afs_pkg::PW-1:0]        prod_reg, prod_next;
    logic [MW+afs_pkg::MCH-1:0]    mpart;
    logic                          mul_done;

    // Unit hookup
    logic                          div_start, sqrt_start, mul_start;
    logic                          div_done, sqrt_done;
    logic [afs_pkg::NUM_W-1:0]     div_num, div_quo;
    logic [afs_pkg::DEN_W-1:0]     div_den;
    logic [afs_pkg::SQ_W-1:0]      sq_root;
    logic [MW-1:0]                 mul_a, mul_b;
    logic [afs_pkg::NUM_W-1:0]     res;

    // Derived operands
    logic signed [afs_pkg::DW:0]   du, dp;
    logic                          du_neg, dp_neg;
    logic [afs_pkg::DW:0]          adu_w, adp_w;
    logic [afs_pkg::MAG_W-1:0]     adu, adp;
    logic [ZW:0]                   zsum;
    logic [ZW-1:0]                 zm, zc;
    logic [afs_pkg::RW-1:0]        rmax;
    logic [TW-1:0]                 tmax;
    logic                          mean_form;

    // Final sums
    logic [SW+29:0]                tp_wide;
    logic [afs_pkg::TP_W-1:0]      tp;
    logic signed [SW-1:0]          su, sp, hu, hp, us, ps;
    logic                          u_hi, u_lo, p_hi, p_lo;
    logic [afs_pkg::DW-1:0]        us_c, ps_c;
    logic                          out_valid_reg, saturated_reg;
    logic [afs_pkg::DW-1:0]        fv_reg, fp_reg;

    assign tau_in = (cell_volume == '0) ? TW'(1) : cell_volume;

    // Differences, magnitudes and face impedance picks
    always_comb
    begin
        du     = $signed({a_vel_reg[afs_pkg::DW-1], a_vel_reg})
               - $signed({b_vel_reg[afs_pkg::DW-1], b_vel_reg});
        dp     = $signed({a_prs_reg[afs_pkg::DW-1], a_prs_reg})
               - $signed({b_prs_reg[afs_pkg::DW-1], b_prs_reg});
        du_neg = du[afs_pkg::DW];
        dp_neg = dp[afs_pkg::DW];
        adu_w  = du_neg ? -du : du;
        adp_w  = dp_neg ? -dp : dp;
        adu    = adu_w[afs_pkg::MAG_W-1:0];
        adp    = adp_w[afs_pkg::MAG_W-1:0];
        zsum   = {1'b0, z0_reg} + {1'b0, z1_reg};
        zm     = (mode_reg == afs_pkg::MODE_MEAN) ? zsum[ZW:1] : zs_reg;
        zc     = (zm == '0) ? ZW'(1) : zm;
        rmax   = (r0_reg > r1_reg) ? r0_reg : r1_reg;
        tmax   = (a_tau_reg > b_tau_reg) ? a_tau_reg : b_tau_reg;
        mean_form = (mode_reg == afs_pkg::MODE_MEAN) || (mode_reg == afs_pkg::MODE_MAX);
    end

    // Operand selection for the shared units
    always_comb
    begin
        case (cmd.uop.num)
            afs_pkg::NUM_C0:   div_num = {{(afs_pkg::NUM_W-TW-afs_pkg::FB){1'b0}}, a_snd_reg,
                                          {afs_pkg::FB{1'b0}}};
            afs_pkg::NUM_C1:   div_num = {{(afs_pkg::NUM_W-TW-afs_pkg::FB){1'b0}}, b_snd_reg,
                                          {afs_pkg::FB{1'b0}}};
            afs_pkg::NUM_ADP:  div_num = {{(afs_pkg::NUM_W-afs_pkg::MAG_W-afs_pkg::FB){1'b0}},
                                          adp, {afs_pkg::FB{1'b0}}};
            afs_pkg::NUM_PROD: div_num = prod_reg[afs_pkg::NUM_W-1:0];
            afs_pkg::NUM_R:    div_num = {rmax, {(afs_pkg::NUM_W-afs_pkg::RW){1'b0}}};
            default:           div_num = '0;
        endcase
        case (cmd.uop.den)
            afs_pkg::DEN_T0: div_den = {{(afs_pkg::DEN_W-TW){1'b0}}, a_tau_reg};
            afs_pkg::DEN_T1: div_den = {{(afs_pkg::DEN_W-TW){1'b0}}, b_tau_reg};
            afs_pkg::DEN_2Z: div_den = {zc, 1'b0};
            afs_pkg::DEN_S:  div_den = zsum;
            afs_pkg::DEN_MI: div_den = {{(afs_pkg::DEN_W-TW){1'b0}}, tmax};
            default:         div_den = {{(afs_pkg::DEN_W-1){1'b0}}, 1'b1};
        endcase
        case (cmd.uop.ma)
            afs_pkg::MA_C0: mul_a = {{(MW-TW){1'b0}}, a_snd_reg};
            afs_pkg::MA_C1: mul_a = {{(MW-TW){1'b0}}, b_snd_reg};
            afs_pkg::MA_Z:  mul_a = {1'b0, zc};
            afs_pkg::MA_Z0: mul_a = {1'b0, z0_reg};
            afs_pkg::MA_Z1: mul_a = {1'b0, z1_reg};
            afs_pkg::MA_H:  mul_a = {1'b0, h_reg};
            default:        mul_a = '0;
        endcase
        case (cmd.uop.mb)
            afs_pkg::MB_C0:  mul_b = {{(MW-TW){1'b0}}, a_snd_reg};
            afs_pkg::MB_C1:  mul_b = {{(MW-TW){1'b0}}, b_snd_reg};
            afs_pkg::MB_ADU: mul_b = {{(MW-afs_pkg::MAG_W){1'b0}}, adu};
            afs_pkg::MB_ADP: mul_b = {{(MW-afs_pkg::MAG_W){1'b0}}, adp};
            afs_pkg::MB_Z1:  mul_b = {1'b0, z1_reg};
            default:         mul_b = '0;
        endcase
    end

    assign div_start  = cmd.start && (cmd.uop.op == afs_pkg::OP_DIV);
    assign sqrt_start = cmd.start && (cmd.uop.op == afs_pkg::OP_SQRT);
    assign mul_start  = cmd.start && (cmd.uop.op == afs_pkg::OP_MUL);

    afs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    afs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (q_reg),
        .root  (sq_root),
        .done  (sqrt_done)
    );

    // Multiplier: one 16-bit chunk of B per cycle, high chunk first
    assign mpart     = ma_reg * mb_reg[MW-1 -: afs_pkg::MCH];
    assign prod_next = {prod_reg[afs_pkg::PW-afs_pkg::MCH-1:0], {afs_pkg::MCH{1'b0}}}
                     + {{(afs_pkg::PW-MW-afs_pkg::MCH){1'b0}}, mpart};
    assign mul_done  = mbusy_reg && (mcnt_reg == MCW'(afs_pkg::MUL_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mcnt_reg  <= '0;
        end
        else if (mul_start)
        begin
            mbusy_reg <= 1'b1;
            mcnt_reg  <= '0;
        end
        else if (mbusy_reg)
        begin
            mcnt_reg <= mcnt_reg + MCW'(1);
            if (mul_done)
                mbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            ma_reg   <= mul_a;
            mb_reg   <= mul_b;
            prod_reg <= '0;
        end
        else if (mbusy_reg)
        begin
            prod_reg <= prod_next;
            mb_reg   <= {mb_reg[MW-afs_pkg::MCH-1:0], {afs_pkg::MCH{1'b0}}};
        end
    end

    // Control state: mode register and row tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= afs_pkg::MODE_WEIGHTED;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                mode_reg <= scheme_mode;
            if (cmd.accept)
                prev_valid_reg <= 1'b1;
        end
    end

    // Shift the held cell back and take the new one
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            a_tau_reg <= b_tau_reg;
            a_vel_reg <= b_vel_reg;
            a_prs_reg <= b_prs_reg;
            a_snd_reg <= b_snd_reg;
            b_tau_reg <= tau_in;
            b_vel_reg <= cell_velocity;
            b_prs_reg <= cell_pressure;
            b_snd_reg <= cell_sound_speed;
        end
    end

    // Write back divider and root results
    assign res = (cmd.uop.op == afs_pkg::OP_SQRT)
               ? {{(afs_pkg::NUM_W-afs_pkg::SQ_W){1'b0}}, sq_root} : div_quo;

    always_ff @(posedge clk)
    begin
        if (div_done || sqrt_done)
        begin
            case (cmd.uop.dst)
                afs_pkg::DST_Z0: z0_reg <= (res[ZW-1:0] == '0) ? ZW'(1) : res[ZW-1:0];
                afs_pkg::DST_Z1: z1_reg <= (res[ZW-1:0] == '0) ? ZW'(1) : res[ZW-1:0];
                afs_pkg::DST_R0: r0_reg <= res[afs_pkg::RW-1:0];
                afs_pkg::DST_R1: r1_reg <= res[afs_pkg::RW-1:0];
                afs_pkg::DST_Q:  q_reg  <= res;
                afs_pkg::DST_ZS: zs_reg <= res[ZW-1:0];
                afs_pkg::DST_TU: tu_reg <= res[ZW-1:0];
                afs_pkg::DST_H:  h_reg  <= res[ZW-1:0];
                afs_pkg::DST_A1: a1_reg <= res[afs_pkg::MAG_W-1:0];
                afs_pkg::DST_B1: b1_reg <= res[afs_pkg::MAG_W-1:0];
                default:         h_reg  <= h_reg;
            endcase
        end
    end

    // Face sums and saturation
    always_comb
    begin
        tp_wide = mean_form ? {1'b0, prod_reg[afs_pkg::PW-1:afs_pkg::FB+1]}
                            : prod_reg[afs_pkg::PW-1:afs_pkg::FB];
        tp      = (tp_wide > {{(SW+30-afs_pkg::TP_W){1'b0}}, afs_pkg::TERM_CAP})
                ? afs_pkg::TERM_CAP : tp_wide[afs_pkg::TP_W-1:0];
        su = ext32(a_vel_reg) + ext32(b_vel_reg);
        sp = ext32(a_prs_reg) + ext32(b_prs_reg);
        hu = (su + $signed({{(SW-1){1'b0}}, su[SW-1]})) >>> 1;
        hp = (sp + $signed({{(SW-1){1'b0}}, sp[SW-1]})) >>> 1;
        if (mean_form)
        begin
            us = hu + apply_sign(dp_neg, {{(SW-ZW){1'b0}}, tu_reg});
            ps = hp + apply_sign(du_neg, {{(SW-afs_pkg::TP_W){1'b0}}, tp});
        end
        else
        begin
            us = ext32(b_vel_reg)
               + apply_sign(du_neg, {{(SW-afs_pkg::MAG_W){1'b0}}, a1_reg})
               + apply_sign(dp_neg, {{(SW-ZW){1'b0}}, tu_reg});
            ps = ext32(b_prs_reg)
               + apply_sign(dp_neg, {{(SW-afs_pkg::MAG_W){1'b0}}, b1_reg})
               + apply_sign(du_neg, {{(SW-afs_pkg::TP_W){1'b0}}, tp});
        end
        u_hi = ~us[SW-1] && (|us[SW-2:afs_pkg::DW-1]);
        u_lo =  us[SW-1] && ~(&us[SW-2:afs_pkg::DW-1]);
        p_hi = ~ps[SW-1] && (|ps[SW-2:afs_pkg::DW-1]);
        p_lo =  ps[SW-1] && ~(&ps[SW-2:afs_pkg::DW-1]);
        us_c = u_hi ? {1'b0, {(afs_pkg::DW-1){1'b1}}}
             : u_lo ? {1'b1, {(afs_pkg::DW-1){1'b0}}} : us[afs_pkg::DW-1:0];
        ps_c = p_hi ? {1'b0, {(afs_pkg::DW-1){1'b1}}}
             : p_lo ? {1'b1, {(afs_pkg::DW-1){1'b0}}} : ps[afs_pkg::DW-1:0];
    end

    // Output register: hold the beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            fv_reg        <= us_c;
            fp_reg        <= ps_c;
            saturated_reg <= u_hi | u_lo | p_hi | p_lo;
        end
    end

    assign out_valid     = out_valid_reg;
    assign face_velocity = $signed(fv_reg);
    assign face_pressure = $signed(fp_reg);
    assign saturated     = saturated_reg;

    assign stat.had      = prev_valid_reg && !first_cell;
    assign stat.done     = div_done || sqrt_done || mul_done;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.mode     = mode_reg;

endmodule

>>> rtl/afs_ctrl.sv
// Controller: steps through the operation program for one face and hands off the result.
module afs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  afs_pkg::dp_stat_t     stat,
    output afs_pkg::ctrl_cmd_t    cmd
);
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ISSUE  = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_FINISH = 4'b1000
    } ctrl_state_t;

    ctrl_state_t                  state_reg, state_next;
    logic [afs_pkg::PC_W-1:0]     pc_reg, pc_next;
    afs_pkg::uop_t                uop;

    assign uop = afs_pkg::prog_step(stat.mode, pc_reg);

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.start    = 1'b0;
        cmd.load_out = 1'b0;
        cmd.uop      = uop;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    pc_next    = '0;
                    if (stat.had)
                        state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (stat.done)
                begin
                    if (uop.last)
                        state_next = ST_FINISH;
                    else
                    begin
                        pc_next    = pc_reg + afs_pkg::PC_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

>>> rtl/acoustic_face_flux_solver.sv
// Top level of the acoustic face flux solver: controller plus datapath.
// Takes one cell beat at a time; a cell that opens a row (or the first after reset) is
// stored and gives no result. Any other cell gives one face beat after a program of
// divides, multiplies and, in the max-based mode, a square root, all run on shared
// iterative units: a divide forms 94 quotient bits, one per cycle, and a multiply sums
// three 48x16 partial products. The weighted program also runs for the unused mode code.
// A finished face beat waits for the output register only while the previous face beat
// still blocks it. The next cell is taken while a finished face beat still waits in the
// output register. The mode register resets to the weighted solver.
module acoustic_face_flux_solver (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         scheme_mode,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [afs_pkg::TW-1:0]             cell_volume,
    input  logic signed [afs_pkg::DW-1:0]      cell_velocity,
    input  logic signed [afs_pkg::DW-1:0]      cell_pressure,
    input  logic [afs_pkg::TW-1:0]             cell_sound_speed,
    input  logic                               first_cell,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [afs_pkg::DW-1:0]      face_velocity,
    output logic signed [afs_pkg::DW-1:0]      face_pressure,
    output logic                               saturated
);
    afs_pkg::ctrl_cmd_t cmd;
    afs_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    afs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    afs_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .scheme_mode      (scheme_mode),
        .cell_volume      (cell_volume),
        .cell_velocity    (cell_velocity),
        .cell_pressure    (cell_pressure),
        .cell_sound_speed (cell_sound_speed),
        .first_cell       (first_cell),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .face_velocity    (face_velocity),
        .face_pressure    (face_pressure),
        .saturated        (saturated),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

>>> verif/acoustic_face_flux_solver_tb.sv
// Self-checking testbench for the acoustic face flux solver: queued driver, monitor, predictor.
module acoustic_face_flux_solver_tb;

    localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, acts as the weighted solver
    localparam longint     Q_MAX      = 64'sd2147483647;
    localparam longint     Q_MIN      = -64'sd2147483648;
    localparam logic [63:0] PROD_CAP  = 64'd1 << 40;
    localparam int         DRAIN_CYC  = 700;

    typedef struct {
        logic [afs_pkg::TW-1:0]        volume;
        logic signed [afs_pkg::DW-1:0] velocity;
        logic signed [afs_pkg::DW-1:0] pressure;
        logic [afs_pkg::TW-1:0]        sound_speed;
        logic                          row_start;
    } cell_t;

    typedef struct {
        logic [afs_pkg::DW-1:0] velocity;
        logic [afs_pkg::DW-1:0] pressure;
        logic                   sat;
    } face_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [1:0]                    scheme_mode;
    logic                          in_valid;
    logic                          in_ready;
    logic [afs_pkg::TW-1:0]        cell_volume;
    logic signed [afs_pkg::DW-1:0] cell_velocity;
    logic signed [afs_pkg::DW-1:0] cell_pressure;
    logic [afs_pkg::TW-1:0]        cell_sound_speed;
    logic                          first_cell;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [afs_pkg::DW-1:0] face_velocity;
    logic signed [afs_pkg::DW-1:0] face_pressure;
    logic                          saturated;

    cell_t      cell_q[$];
    face_t      face_q[$];
    cell_t      held_cell;
    logic       held_ok;
    logic [1:0] solver_mode;
    logic       in_taken;
    logic       cfg_taken;
    logic       stall_on;
    int         burst_left;
    int         gap_left;
    int         errors;

    acoustic_face_flux_solver u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .scheme_mode      (scheme_mode),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cell_volume      (cell_volume),
        .cell_velocity    (cell_velocity),
        .cell_pressure    (cell_pressure),
        .cell_sound_speed (cell_sound_speed),
        .first_cell       (first_cell),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .face_velocity    (face_velocity),
        .face_pressure    (face_pressure),
        .saturated        (saturated)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Truncating divide, pinned to all ones when the divisor is zero or the quotient overflows 64 bits
    function automatic logic [63:0] udiv_sat(input logic [127:0] num, input logic [63:0] den);
        logic [127:0] q;
        if (den == 0 || num[127:64] >= den)
            return '1;
        q = num / den;
        return q[63:0];
    endfunction

    // (a * b) >> s with the term capped
    function automatic logic [63:0] prod_shift(input logic [63:0] a, input logic [63:0] b,
                                               input int s);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> s;
        return (p > PROD_CAP) ? PROD_CAP : p[63:0];
    endfunction

    function automatic longint with_sign(input logic neg, input logic [63:0] mag);
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [63:0] cell_impedance(input logic [63:0] c, input logic [63:0] tau);
        logic [63:0] z;
        z = udiv_sat({64'd0, c} << afs_pkg::FB, tau);
        return (z == 0) ? 64'd1 : z;
    endfunction

    // sqrt(max(c^2/tau) / max(tau)) by bitwise search
    function automatic logic [63:0] max_impedance(input logic [63:0] c0, input logic [63:0] t0,
                                                  input logic [63:0] c1, input logic [63:0] t1);
        logic [63:0]  r0;
        logic [63:0]  r1;
        logic [63:0]  r;
        logic [63:0]  tmax;
        logic [63:0]  z;
        logic [63:0]  trial;
        logic [127:0] lhs;
        logic [127:0] rhs;
        r0 = (c0 * c0) / t0;
        r1 = (c1 * c1) / t1;
        r = (r0 > r1) ? r0 : r1;
        tmax = (t0 > t1) ? t0 : t1;
        rhs = {64'd0, r} << (2 * afs_pkg::FB);
        z = 0;
        for (int b = afs_pkg::DW + afs_pkg::FB - 1; b >= 0; b--)
        begin
            trial = z | (64'd1 << b);
            lhs = {64'd0, trial} * {64'd0, trial} * {64'd0, tmax};
            if (lhs <= rhs)
                z = trial;
        end
        return (z == 0) ? 64'd1 : z;
    endfunction

    function automatic longint clip_q(input longint v, inout logic sat);
        if (v > Q_MAX)
        begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            sat = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // Face state between the held cell (left) and the new cell (right)
    function automatic face_t face_flux(input cell_t lc, input cell_t rc, input logic [1:0] m);
        logic [63:0] t0;
        logic [63:0] t1;
        logic [63:0] c0;
        logic [63:0] c1;
        logic [63:0] adu;
        logic [63:0] adp;
        logic [63:0] z;
        logic [63:0] z0;
        logic [63:0] z1;
        logic [63:0] zsum;
        logic [63:0] zh;
        longint      u0;
        longint      u1;
        longint      p0;
        longint      p1;
        longint      du;
        longint      dp;
        longint      us;
        longint      ps;
        logic        sat;
        face_t       f;
        t0 = lc.volume;
        t1 = rc.volume;
        c0 = lc.sound_speed;
        c1 = rc.sound_speed;
        u0 = lc.velocity;
        u1 = rc.velocity;
        p0 = lc.pressure;
        p1 = rc.pressure;
        du = u0 - u1;
        dp = p0 - p1;
        adu = (du < 0) ? -du : du;
        adp = (dp < 0) ? -dp : dp;
        sat = 1'b0;
        if (m == afs_pkg::MODE_MEAN || m == afs_pkg::MODE_MAX)
        begin
            if (m == afs_pkg::MODE_MEAN)
                z = (cell_impedance(c0, t0) + cell_impedance(c1, t1)) / 2;
            else
                z = max_impedance(c0, t0, c1, t1);
            if (z == 0)
                z = 1;
            us = (u0 + u1) / 2
               + with_sign(dp < 0, udiv_sat({64'd0, adp} << afs_pkg::FB, 2 * z));
            ps = (p0 + p1) / 2 + with_sign(du < 0, prod_shift(z, adu, afs_pkg::FB + 1));
        end
        else
        begin
            z0 = cell_impedance(c0, t0);
            z1 = cell_impedance(c1, t1);
            zsum = z0 + z1;
            zh = udiv_sat({64'd0, z0} * {64'd0, z1}, zsum);
            us = u1 + with_sign(du < 0, udiv_sat({64'd0, z0} * {64'd0, adu}, zsum))
                    + with_sign(dp < 0, udiv_sat({64'd0, adp} << afs_pkg::FB, zsum));
            ps = p1 + with_sign(dp < 0, udiv_sat({64'd0, z1} * {64'd0, adp}, zsum))
                    + with_sign(du < 0, prod_shift(zh, adu, afs_pkg::FB));
        end
        us = clip_q(us, sat);
        ps = clip_q(ps, sat);
        f.velocity = us[31:0];
        f.pressure = ps[31:0];
        f.sat = sat;
        return f;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch %s: expected %h, got %h", field, want, got);
        errors++;
    endtask

    // Track accepted cells, predict faces, follow mode writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            cfg_taken <= 1'b0;
            held_ok <= 1'b0;
            solver_mode <= afs_pkg::MODE_WEIGHTED;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            cfg_taken <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
                solver_mode <= scheme_mode;
            if (in_valid && in_ready)
            begin
                cell_t c;
                c.volume = (cell_volume == 0) ? afs_pkg::TW'(1) : cell_volume;
                c.velocity = cell_velocity;
                c.pressure = cell_pressure;
                c.sound_speed = cell_sound_speed;
                c.row_start = first_cell;
                if (held_ok && !first_cell)
                    face_q.push_back(face_flux(held_cell, c, solver_mode));
                held_cell <= c;
                held_ok <= 1'b1;
            end
        end
    end

    // Check each face beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            face_t f;
            if (face_q.size() == 0)
                report_mismatch("unexpected face_velocity", 32'd0, face_velocity);
            else
            begin
                f = face_q.pop_front();
                if (face_velocity !== f.velocity)
                    report_mismatch("face_velocity", f.velocity, face_velocity);
                if (face_pressure !== f.pressure)
                    report_mismatch("face_pressure", f.pressure, face_pressure);
                if (saturated !== f.sat)
                    report_mismatch("saturated", 32'(f.sat), 32'(saturated));
            end
        end
    end

    // Drive cells in bursts with random gaps; hold a beat until it is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (cell_q.size() > 0)
            begin
                cell_t c;
                c = cell_q.pop_front();
                cell_volume <= c.volume;
                cell_velocity <= c.velocity;
                cell_pressure <= c.pressure;
                cell_sound_speed <= c.sound_speed;
                first_cell <= c.row_start;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 8);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: free-running or stalling on a random pattern, chosen per phase
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    function automatic logic [afs_pkg::TW-1:0] pick_pos();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return afs_pkg::TW'($urandom_range(1, 255));
            3: return afs_pkg::TW'($urandom_range(1 << 16, 1 << 20));
            default: return afs_pkg::TW'($urandom);
        endcase
    endfunction

    function automatic logic [afs_pkg::DW-1:0] pick_signed();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_cell(input logic [afs_pkg::TW-1:0] v, input logic [afs_pkg::DW-1:0] u,
                            input logic [afs_pkg::DW-1:0] p, input logic [afs_pkg::TW-1:0] c,
                            input logic rs);
        cell_t x;
        x.volume = v;
        x.velocity = u;
        x.pressure = p;
        x.sound_speed = c;
        x.row_start = rs;
        cell_q.push_back(x);
    endtask

    // Wait until every cell is in and every face is out, then let the block settle
    task automatic drain();
        while (cell_q.size() > 0 || in_valid || face_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        @(negedge clk);
        scheme_mode <= m;
        cfg_valid <= 1'b1;
        @(negedge clk);
        while (!cfg_taken)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [1:0] modes[6];
        errors = 0;
        burst_left = 0;
        gap_left = 0;
        stall_on = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        scheme_mode = afs_pkg::MODE_MEAN;
        in_valid = 1'b0;
        cell_volume = '0;
        cell_velocity = '0;
        cell_pressure = '0;
        cell_sound_speed = '0;
        first_cell = 1'b0;
        out_ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed cells under the reset mode: no held cell, row starts, extremes
        add_cell(31'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h0001_0000, 1'b0);
        add_cell(31'h0001_0000, 32'h0000_0000, 32'h0000_0000, 31'h0001_0000, 1'b0);
        add_cell(31'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 1'b0);
        add_cell(31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 31'h0000_0000, 1'b0);
        add_cell(31'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, 1'b0);
        add_cell(31'h0000_0001, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff, 1'b0);
        add_cell(31'h0002_0000, 32'hffff_0000, 32'h0003_0000, 31'h0000_0001, 1'b1);
        add_cell(31'h7fff_ffff, 32'h0002_0000, 32'hfffd_0000, 31'h0000_0000, 1'b0);
        add_cell(31'h0000_8000, 32'h0000_0001, 32'hffff_ffff, 31'h0005_0000, 1'b0);
        add_cell(31'h0000_8000, 32'h0000_0001, 32'hffff_ffff, 31'h0005_0000, 1'b0);
        add_cell(31'h0001_0000, 32'h1234_5678, 32'hedcb_a988, 31'h0100_0000, 1'b1);
        add_cell(31'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 31'h0000_0000, 1'b1);
        add_cell(31'h2aaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 31'h5555_5555, 1'b0);
        drain();

        // Random phases, each under one mode setting
        modes = '{afs_pkg::MODE_MEAN, afs_pkg::MODE_MAX, afs_pkg::MODE_WEIGHTED, MODE_SPARE,
                  afs_pkg::MODE_MAX, afs_pkg::MODE_MEAN};
        foreach (modes[i])
        begin
            write_mode(modes[i]);
            stall_on = i[0];
            for (int n = 0; n < 65; n++)
                add_cell(pick_pos(), pick_signed(), pick_signed(), pick_pos(),
                         $urandom_range(0, 9) == 0);
            drain();
        end

        if (errors == 0)
            $display("** acoustic_face_flux_solver: PASSED **");
        else
            $display("** acoustic_face_flux_solver: FAILED **");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("** acoustic_face_flux_solver: FAILED **");
        $finish;
    end

endmodule

>>> acoustic_face_flux_solver.f
rtl/afs_pkg.sv
rtl/afs_div.sv
rtl/afs_sqrt.sv
rtl/afs_dp.sv
rtl/afs_ctrl.sv
rtl/acoustic_face_flux_solver.sv
verif/acoustic_face_flux_solver_tb.sv
